[hdl/rau_pkg.sv]
`default_nettype none
package rau_pkg;
    localparam int OperandWidth = 32;
    localparam int WideWidth = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_LT  = 3'd4,
        OP_EQ  = 3'd5
    } t_op;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [2:0]  op;
        logic        a_nan;
        logic        b_nan;
        logic [63:0] na;
        logic [63:0] da;
        logic [63:0] nb;
        logic [63:0] db;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_GCD_DEN,
        S_DIVA,
        S_DIVB,
        S_SCALE1,
        S_SCALE2,
        S_FIN_PREP,
        S_GCD_FIN,
        S_DIVN,
        S_DIVD,
        S_EMIT
    } t_state;
endpackage
`default_nettype wire

[hdl/rau_front.sv]
`default_nettype none
module rau_front #(
    parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [2:0]    i_op,
    input  wire logic [31:0]   i_a_num,
    input  wire logic [30:0]   i_a_den,
    input  wire logic [31:0]   i_b_num,
    input  wire logic [30:0]   i_b_den,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rau_pkg::t_job      o_job
);
    // Two-entry queue toward the back part.
    rau_pkg::t_job r_q [2];
    logic r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    rau_pkg::t_job w_job;
    logic w_push, w_pop;

    // Take the operand bits and classify NaN operands.
    always_comb begin
        logic [OPERAND_WIDTH-1:0] an, bn;
        logic [OPERAND_WIDTH-2:0] ad, bd;
        an = i_a_num[OPERAND_WIDTH-1:0];
        bn = i_b_num[OPERAND_WIDTH-1:0];
        ad = i_a_den[OPERAND_WIDTH-2:0];
        bd = i_b_den[OPERAND_WIDTH-2:0];
        w_job.op = i_op;
        w_job.na = 64'(signed'(an));
        w_job.nb = 64'(signed'(bn));
        w_job.da = 64'(ad);
        w_job.db = 64'(bd);
        w_job.a_nan = (ad == '0);
        w_job.b_nan = (bd == '0);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_comb begin
        n_wp = r_wp ^ w_push;
        n_rp = r_rp ^ w_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end
endmodule
`default_nettype wire

[hdl/rau_back.sv]
`default_nettype none
module rau_back #(
    parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  rau_pkg::t_job    i_job,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_num,
    output logic [30:0]      o_den,
    output logic             o_cmp,
    output logic             o_nan,
    output logic             o_ovf
);
    localparam int W = rau_pkg::WideWidth;

    rau_pkg::t_state r_state, n_state;
    rau_pkg::t_job r_job;
    logic [W-1:0] r_x, r_y, r_g, r_m, r_d, r_p0, r_p1, r_q, r_rem;
    logic [5:0] r_k;
    logic [6:0] r_cnt;
    logic r_neg, r_inner;
    logic [W-1:0] r_num;
    logic [W-1:0] r_den;
    logic r_cmp;
    logic r_ov;

    // Binary gcd step and restoring divider step.
    logic w_gcd_done, w_div_done;
    logic [W-1:0] w_rem_sh, w_rem_sub;
    logic [W-1:0] w_lo, w_hi;
    assign w_gcd_done = (r_y == '0);
    assign w_div_done = (r_cnt == 7'd0);
    assign w_rem_sh = {r_rem[W-2:0], r_q[W-1]};
    assign w_rem_sub = w_rem_sh - r_g;
    assign w_hi = (W)'(({{(W-OPERAND_WIDTH){1'b0}}, 1'b1, {(OPERAND_WIDTH-1){1'b0}}}) - 1);
    assign w_lo = ~w_hi;

    // Unsigned 32x32 product, combinational; its callers register it.
    function automatic logic [W-1:0] umul(input logic [W-1:0] a, input logic [W-1:0] b);
        return a[31:0] * b[31:0];
    endfunction
    function automatic logic [W-1:0] absv(input logic [W-1:0] a);
        return a[W-1] ? (W)'(-a) : a;
    endfunction

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rau_pkg::S_IDLE:     if (i_valid) n_state = rau_pkg::S_MUL1;
            rau_pkg::S_MUL1:     n_state = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2:     n_state = rau_pkg::S_GCD_DEN;
            rau_pkg::S_GCD_DEN:  if (w_gcd_done && !r_inner) n_state = rau_pkg::S_DIVA;
            rau_pkg::S_DIVA:     if (w_div_done) n_state = rau_pkg::S_DIVB;
            rau_pkg::S_DIVB:     if (w_div_done) n_state = rau_pkg::S_SCALE1;
            rau_pkg::S_SCALE1:   n_state = rau_pkg::S_SCALE2;
            rau_pkg::S_SCALE2:   n_state = rau_pkg::S_FIN_PREP;
            rau_pkg::S_FIN_PREP: n_state = rau_pkg::S_GCD_FIN;
            rau_pkg::S_GCD_FIN:  if (w_gcd_done && !r_inner) n_state = rau_pkg::S_DIVN;
            rau_pkg::S_DIVN:     if (w_div_done) n_state = rau_pkg::S_DIVD;
            rau_pkg::S_DIVD:     if (w_div_done) n_state = rau_pkg::S_EMIT;
            rau_pkg::S_EMIT:     if (i_ready) n_state = rau_pkg::S_IDLE;
            default:             n_state = rau_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready = (r_state == rau_pkg::S_IDLE);
        o_valid = (r_state == rau_pkg::S_EMIT);
        o_num = r_num[31:0];
        o_den = r_den[30:0];
        o_cmp = r_cmp;
        o_nan = (r_den == '0);
        o_ovf = r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath. Flow: products, gcd of denominators, division by it, scaling, final gcd, reduce.
    always_ff @(posedge i_clk) begin
        logic [W-1:0] sum, n_abs, d_abs, nv;
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                r_job <= i_job;
                r_inner <= 1'b0;
            end
            rau_pkg::S_MUL1: begin
                // Products used by multiply, divide and compare.
                unique case (r_job.op)
                    rau_pkg::OP_MUL: begin
                        r_p0 <= umul(absv(r_job.na), absv(r_job.nb));
                        r_p1 <= umul(r_job.da, r_job.db);
                    end
                    rau_pkg::OP_DIV: begin
                        r_p0 <= umul(absv(r_job.na), r_job.db);
                        r_p1 <= umul(r_job.da, absv(r_job.nb));
                    end
                    default: begin
                        r_p0 <= umul(absv(r_job.na), r_job.db);
                        r_p1 <= umul(absv(r_job.nb), r_job.da);
                    end
                endcase
                r_x <= r_job.da;
                r_y <= r_job.db;
                r_k <= '0;
            end
            rau_pkg::S_MUL2: begin
                // Apply signs to the products.
                unique case (r_job.op)
                    rau_pkg::OP_MUL: r_p0 <= (r_job.na[W-1] ^ r_job.nb[W-1]) ?
                                             (W)'(-r_p0) : r_p0;
                    rau_pkg::OP_DIV: begin
                        // A zero denominator product leaves the sign of a_num alone.
                        r_p0 <= (r_job.na[W-1] ^ (r_job.nb[W-1] && !r_job.a_nan)) ?
                                (W)'(-r_p0) : r_p0;
                    end
                    default: begin
                        r_p0 <= r_job.na[W-1] ? (W)'(-r_p0) : r_p0;
                        r_p1 <= r_job.nb[W-1] ? (W)'(-r_p1) : r_p1;
                    end
                endcase
            end
            rau_pkg::S_GCD_DEN, rau_pkg::S_GCD_FIN: begin
                // Binary gcd: strip common twos, then subtract.
                if (r_inner) begin
                    r_inner <= 1'b0;
                end else if (r_x == '0) begin
                    r_x <= r_y;
                    r_y <= '0;
                end else if (!w_gcd_done) begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + 6'd1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x > r_y) begin
                        r_x <= r_x - r_y;
                    end else begin
                        r_y <= r_y - r_x;
                    end
                end
                if (w_gcd_done && !r_inner) begin
                    r_g <= r_x << r_k;
                    r_q <= (r_state == rau_pkg::S_GCD_DEN) ? r_job.da : r_m;
                    r_rem <= '0;
                    r_cnt <= 7'(W);
                end
            end
            rau_pkg::S_DIVA, rau_pkg::S_DIVB, rau_pkg::S_DIVN, rau_pkg::S_DIVD: begin
                if (!w_div_done) begin
                    if (!w_rem_sub[W-1] || r_rem[W-1]) begin
                        r_rem <= w_rem_sub;
                        r_q <= {r_q[W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_q <= {r_q[W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 7'd1;
                end else if (r_state == rau_pkg::S_DIVA) begin
                    // da/g is ready; divide db by the same gcd next.
                    r_x <= r_q;
                    r_q <= r_job.db;
                    r_rem <= '0;
                    r_cnt <= 7'(W);
                end else if (r_state == rau_pkg::S_DIVB) begin
                    r_y <= r_q;
                end else if (r_state == rau_pkg::S_DIVN) begin
                    r_m <= r_q;
                    r_q <= r_d;
                    r_rem <= '0;
                    r_cnt <= 7'(W);
                end else if (r_job.op == rau_pkg::OP_LT || r_job.op == rau_pkg::OP_EQ) begin
                    // Compares return 0/1 with the flag.
                    r_num <= '0;
                    r_den <= 64'd1;
                    r_ov <= 1'b0;
                    r_cmp <= !r_job.a_nan && !r_job.b_nan &&
                             ((r_job.op == rau_pkg::OP_LT) ? ($signed(r_p0) < $signed(r_p1))
                                                           : (r_p0 == r_p1));
                end else begin
                    nv = r_neg ? (W)'(-r_m) : r_m;
                    r_num <= nv;
                    r_den <= r_q;
                    r_ov <= ($signed(nv) > $signed(w_hi)) || ($signed(nv) < $signed(w_lo))
                            || (r_q > w_hi);
                    r_cmp <= 1'b0;
                end
            end
            rau_pkg::S_SCALE1: begin
                // r_x holds da/g and r_y holds db/g: scale operands and form lcm.
                if (r_job.op == rau_pkg::OP_ADD || r_job.op == rau_pkg::OP_SUB) begin
                    r_p0 <= umul(absv(r_job.na), r_y);
                    r_p1 <= umul(r_x, r_job.db);
                    r_m <= umul(absv(r_job.nb), r_x);
                end
            end
            rau_pkg::S_SCALE2: begin
                r_d <= r_p1;
            end
            rau_pkg::S_FIN_PREP: begin
                // Build the unreduced result for every operation.
                r_k <= '0;
                r_cmp <= 1'b0;
                r_ov <= 1'b0;
                sum = '0;
                unique case (r_job.op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                        n_abs = r_job.na[W-1] ? (W)'(-r_p0) : r_p0;
                        d_abs = r_job.nb[W-1] ? (W)'(-r_m) : r_m;
                        sum = (r_job.op == rau_pkg::OP_ADD) ? n_abs + d_abs : n_abs - d_abs;
                    end
                    default: sum = '0;
                endcase
                r_num <= '0;
                r_den <= '0;
                priority if (r_job.op == rau_pkg::OP_ADD || r_job.op == rau_pkg::OP_SUB) begin
                    if (r_job.a_nan || r_job.b_nan) begin
                        r_m <= '0; r_d <= '0; r_neg <= 1'b0;
                    end else if (sum == '0) begin
                        r_m <= '0; r_d <= 64'd1; r_neg <= 1'b0;
                    end else begin
                        r_m <= absv(sum); r_neg <= sum[W-1];
                    end
                end else if (r_job.op == rau_pkg::OP_MUL || r_job.op == rau_pkg::OP_DIV) begin
                    r_m <= absv(r_p0); r_neg <= r_p0[W-1]; r_d <= r_p1;
                end else begin
                    r_m <= '0; r_neg <= 1'b0;
                    r_d <= (r_job.op == rau_pkg::OP_LT || r_job.op == rau_pkg::OP_EQ)
                           ? 64'd1 : '0;
                end
                r_x <= '0;
                r_y <= '0;
            end
            default: ;
        endcase
        // Seed the final gcd once the unreduced result is ready.
        if (r_state == rau_pkg::S_FIN_PREP) begin
            r_inner <= 1'b1;
        end
        if (r_state == rau_pkg::S_GCD_FIN && r_inner) begin
            if (r_d == '0) begin
                r_x <= 64'd1;
                r_y <= '0;
            end else if (r_m == '0) begin
                r_x <= r_d;
                r_y <= r_d;
            end else begin
                r_x <= r_m;
                r_y <= r_d;
            end
        end
    end
endmodule
`default_nettype wire

[hdl/rational_arithmetic_unit.sv]
`default_nettype none
// Rational arithmetic unit.
// Input channel s_axis: one item per operation; output channel m_axis: one
// result item per input item, in order.
// Each item is classified and queued by the front part (two entries), then
// worked by a back sequencer that owns one 64-bit binary gcd unit and one
// bit-serial 64-step divider. Each item runs four divisions and two gcd
// passes (one over the denominators and one over the result); the
// sequencer handles one item at a time and takes a new one only once
// the current result has been taken.
// The result register holds the item until m_axis_tready; while it waits
// the front queue still accepts up to two more items.
// A synchronous active-low reset empties the queue and returns the
// sequencer to idle; no result is pending after reset.
// Compares pass through the same sequence and return 0/1 with the flag.
// Unused operation codes return NaN (0/0).
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // operation[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98], zeros
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_num[31:0], result_den[62:32], compare_true[63], is_nan[64], overflow[65]
    output logic [71:0]       m_axis_tdata
);
    logic w_v, w_r;
    rau_pkg::t_job w_job;
    logic [31:0] w_num;
    logic [30:0] w_den;
    logic w_cmp, w_nan, w_ovf;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[2:0]), .i_a_num(s_axis_tdata[34:3]),
        .i_a_den(s_axis_tdata[65:35]), .i_b_num(s_axis_tdata[97:66]),
        .i_b_den(s_axis_tdata[128:98]),
        .o_valid(w_v), .i_ready(w_r), .o_job(w_job)
    );

    rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_v), .o_ready(w_r), .i_job(w_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_num(w_num), .o_den(w_den), .o_cmp(w_cmp), .o_nan(w_nan), .o_ovf(w_ovf)
    );

    assign m_axis_tdata = {6'd0, w_ovf, w_nan, w_cmp, w_den, w_num};
endmodule
`default_nettype wire

[hdl/rau_checker.sv]
`default_nettype none
module rau_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [71:0]  m_axis_tdata
);
    // A pending result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    // is_nan comes only with a zero denominator field.
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> (m_axis_tdata[62:32] == 31'd0))
        else $error("is_nan inconsistent");
    // Compare flag only comes with 0/1.
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[63] |->
            m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[62:32] == 31'd1)
        else $error("compare result not 0/1");
    // No result and s_axis_tready set in the cycle after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("result after reset");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk, .i_rst_n, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
